>>> sv/pit_pkg.sv
// ----------------------------------------------------------------------------
// Pausable interval timer package
// Opcodes, field widths and register map shared by the timer RTL.
// ----------------------------------------------------------------------------
package pit_pkg;

	localparam int unsigned OpW     = 3;
	localparam int unsigned PeriodW = 32;
	localparam int unsigned TickW   = 32;
	localparam int unsigned TimeW   = 64;
	localparam int unsigned ApbDataW = 32;
	localparam int unsigned ApbAddrW = 3;

	// Word index of the auto-reload register on the configuration port.
	localparam logic [ApbAddrW-3:0] RegAutoReload = '0;

	typedef enum logic [OpW-1:0] {
		OP_START  = 3'd0,
		OP_STOP   = 3'd1,
		OP_PAUSE  = 3'd2,
		OP_RESUME = 3'd3,
		OP_POLL   = 3'd4
	} op_t;

endpackage

>>> sv/pausable_interval_timer.sv
// ----------------------------------------------------------------------------
// Pausable interval timer
// One-shot or periodic timer driven by start, stop, pause, resume and poll.
// ----------------------------------------------------------------------------
// Each input word carries one command together with a sample of the free-running
// millisecond tick and the 64-bit microsecond counter. The timer takes one word
// per clock cycle while the result channel does not stall. A word is captured into an
// input register. Once the output register is empty or its word is being taken, the
// word is evaluated against the timer state in one pass, and that pass writes both
// the state and the output register. The throughput is one word per cycle while the
// receiver does not stall. The datapath thus has two registers, input and output.
// The longest logic between them is the 64-bit subtract-and-compare path from the
// sampled time through the elapsed time to the expiry decision.
// Every command yields exactly one result word. In millisecond mode the 32-bit
// tick is extended to 64 bits by counting its wraps whenever the clock is read.
// In microsecond mode the counter is used as it stands. Time spent paused is left
// out of the elapsed time. The only configuration register is auto_reload at byte
// address 0. When it is set, a poll that finds the period reached restarts the
// period at the poll time; otherwise the poll stops the timer. Configuration
// should be written while the timer is idle.
// ----------------------------------------------------------------------------
module pausable_interval_timer
	import pit_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	// Configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready,

	// Command channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OpW-1:0]      opcode,
	input  logic [PeriodW-1:0]  period_value,
	input  logic                unit_select,
	input  logic [TickW-1:0]    raw_ms_tick,
	input  logic [TimeW-1:0]    us_count,

	// Result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                expired_flag,
	output logic [TimeW-1:0]    elapsed_time,
	output logic [TimeW-1:0]    remaining_time,
	output logic                is_running,
	output logic                is_paused
);

	// ------------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------------
	logic auto_reload_q;
	logic cfg_sel_auto;

	assign pready       = 1'b1;
	assign cfg_sel_auto = (paddr[ApbAddrW-1:2] == RegAutoReload);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_reload_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && cfg_sel_auto) begin
			auto_reload_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (cfg_sel_auto) begin
			prdata[0] = auto_reload_q;
		end
	end

	// ------------------------------------------------------------------------
	// Input register. The stage moves on whenever the output register is
	// empty or its word is being taken in this cycle.
	// ------------------------------------------------------------------------
	logic               valid_s1;
	logic [OpW-1:0]     opcode_s1;
	logic [PeriodW-1:0] period_s1;
	logic               unit_s1;
	logic [TickW-1:0]   tick_s1;
	logic [TimeW-1:0]   us_s1;
	logic               advance;
	logic               fire;
	logic               in_take;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1 <= opcode;
			period_s1 <= period_value;
			unit_s1   <= unit_select;
			tick_s1   <= raw_ms_tick;
			us_s1     <= us_count;
		end
	end

	// ------------------------------------------------------------------------
	// Timer state. Instead of keeping the start time and the accumulated
	// pause time apart, the timer keeps their sum (base_q): the elapsed time
	// of a running timer is then the current time minus base, and that of a
	// paused timer is the pause start minus base, which no longer depends on
	// the current time.
	// ------------------------------------------------------------------------
	logic               running_q;
	logic               paused_q;
	logic               micro_mode_q;
	logic [PeriodW-1:0] period_q;
	logic [TimeW-1:0]   base_q;
	logic [TimeW-1:0]   pause_begin_q;
	logic [TickW-1:0]   last_tick_q;
	logic [TickW-1:0]   ms_high_q;

	logic               running_d;
	logic               paused_d;
	logic               micro_mode_d;
	logic [PeriodW-1:0] period_d;
	logic [TimeW-1:0]   base_d;
	logic [TimeW-1:0]   pause_begin_d;
	logic [TickW-1:0]   last_tick_d;
	logic [TickW-1:0]   ms_high_d;

	logic               read_clk;
	logic               read_micro;
	logic [TickW-1:0]   ms_high_ext;
	logic [TimeW-1:0]   now_time;
	logic [TimeW-1:0]   elapsed_c;
	logic [TimeW:0]     diff_c;
	logic               reached_c;
	logic               expired_d;
	logic [TimeW-1:0]   elapsed_d;
	logic [TimeW-1:0]   remaining_d;
	op_t                op_c;

	assign op_c = op_t'(opcode_s1);

	// The clock is read by start, by a pause or resume that takes effect and
	// by a poll of a running timer. A start reads it in its own new unit.
	always_comb begin
		read_clk = 1'b0;
		unique case (op_c)
			OP_START:  read_clk = 1'b1;
			OP_PAUSE:  read_clk = running_q && !paused_q;
			OP_RESUME: read_clk = running_q && paused_q;
			OP_POLL:   read_clk = running_q;
			default:   read_clk = 1'b0;
		endcase
	end

	assign read_micro  = (op_c == OP_START) ? unit_s1 : micro_mode_q;
	assign ms_high_ext = (tick_s1 < last_tick_q) ? ms_high_q + TickW'(1) : ms_high_q;
	assign now_time    = read_micro ? us_s1 : {ms_high_ext, tick_s1};

	// Elapsed time at the sampled instant and the expiry compare.
	assign elapsed_c = paused_q ? (pause_begin_q - base_q) : (now_time - base_q);
	assign diff_c    = {1'b0, {(TimeW-PeriodW){1'b0}}, period_q} - {1'b0, elapsed_c};
	assign reached_c = diff_c[TimeW];
	// reached_c is set when the subtraction borrows, i.e. elapsed > period;
	// the equal case is caught separately below.

	always_comb begin
		running_d     = running_q;
		paused_d      = paused_q;
		micro_mode_d  = micro_mode_q;
		period_d      = period_q;
		base_d        = base_q;
		pause_begin_d = pause_begin_q;
		last_tick_d   = last_tick_q;
		ms_high_d     = ms_high_q;
		expired_d     = 1'b0;
		elapsed_d     = '0;
		remaining_d   = '0;

		// Millisecond extension advances on every clock read in that unit.
		if (read_clk && !read_micro) begin
			last_tick_d = tick_s1;
			ms_high_d   = ms_high_ext;
		end

		unique case (op_c)
			OP_START: begin
				micro_mode_d = unit_s1;
				period_d     = period_s1;
				base_d       = now_time;
				paused_d     = 1'b0;
				running_d    = 1'b1;
			end
			OP_STOP: begin
				running_d = 1'b0;
				paused_d  = 1'b0;
			end
			OP_PAUSE: begin
				if (running_q && !paused_q) begin
					pause_begin_d = now_time;
					paused_d      = 1'b1;
				end
			end
			OP_RESUME: begin
				if (running_q && paused_q) begin
					base_d   = base_q + (now_time - pause_begin_q);
					paused_d = 1'b0;
				end
			end
			OP_POLL: begin
				if (running_q) begin
					elapsed_d = elapsed_c;
					if (reached_c || (diff_c[TimeW-1:0] == '0)) begin
						expired_d = 1'b1;
						if (auto_reload_q) begin
							base_d   = now_time;
							paused_d = 1'b0;
						end else begin
							running_d = 1'b0;
						end
					end else begin
						remaining_d = diff_c[TimeW-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			paused_q      <= 1'b0;
			micro_mode_q  <= 1'b0;
			period_q      <= '0;
			base_q        <= '0;
			pause_begin_q <= '0;
			last_tick_q   <= '0;
			ms_high_q     <= '0;
		end else if (fire) begin
			running_q     <= running_d;
			paused_q      <= paused_d;
			micro_mode_q  <= micro_mode_d;
			period_q      <= period_d;
			base_q        <= base_d;
			pause_begin_q <= pause_begin_d;
			last_tick_q   <= last_tick_d;
			ms_high_q     <= ms_high_d;
		end
	end

	// ------------------------------------------------------------------------
	// Output register. It holds its word while the receiver stalls.
	// ------------------------------------------------------------------------
	logic             out_valid_q;
	logic             expired_q;
	logic [TimeW-1:0] elapsed_q;
	logic [TimeW-1:0] remaining_q;
	logic             is_running_q;
	logic             is_paused_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			expired_q    <= expired_d;
			elapsed_q    <= elapsed_d;
			remaining_q  <= remaining_d;
			is_running_q <= running_d;
			is_paused_q  <= paused_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign expired_flag   = expired_q;
	assign elapsed_time   = elapsed_q;
	assign remaining_time = remaining_q;
	assign is_running     = is_running_q;
	assign is_paused      = is_paused_q;

endmodule
